// ===== rtl/centered_moving_average_unit_macros.svh =====
// ----------------------------------------------------------------------------
// centered moving average assertion macros
// concurrent checks clocked on i_clk and disabled while i_rst_n is low
// ----------------------------------------------------------------------------
`ifndef CENTERED_MOVING_AVERAGE_UNIT_MACROS_SVH
`define CENTERED_MOVING_AVERAGE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication
`define CMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define CMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CMA_ASSERT_IMP(lbl, ante, cons, msg)
`define CMA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

// ===== rtl/cma_pkg.sv =====
// ----------------------------------------------------------------------------
// cma_pkg
// constants, command/status types and helpers shared by the centered
// moving average controller, datapath and top level
// ----------------------------------------------------------------------------
package cma_pkg;

    // sizing
    localparam int MAX_WINDOW = 64;
    localparam int VALUE_W    = 32;
    localparam int FIELD_W    = 32;
    localparam int CFG_W      = 7;
    localparam int MAX_HALF   = MAX_WINDOW / 2;
    localparam int SPAN_MAX   = 2 * MAX_HALF + 1;
    localparam int HALF_W     = $clog2(MAX_HALF + 1);
    localparam int CNT_W      = $clog2(SPAN_MAX + 1);
    localparam int SUM_W      = VALUE_W + CNT_W;
    localparam int DCNT_W     = $clog2(SUM_W + 1);
    localparam int ADDR_W     = $clog2(SPAN_MAX + 1);
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int MEM_W      = VALUE_W + 2 * FIELD_W;

    // register port
    localparam int PADDR_W       = 3;
    localparam int PDATA_W       = 32;
    localparam int WINDOW_RESET  = 5;
    localparam logic REG_WINDOW  = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic accept;
        logic sub;
        logic setup;
        logic tgt;
        logic trim;
        logic div_start;
        logic emit;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic has_result;
        logic need_trim;
        logic div_busy;
        logic out_free;
        logic final_result;
    } t_sts;

    // half span from the window register, zero treated as one, capped
    function automatic logic [HALF_W-1:0] eff_half(input logic [CFG_W-1:0] window);
        logic [HALF_W-1:0] h;
        if (window > CFG_W'(MAX_WINDOW)) begin
            h = HALF_W'(MAX_HALF);
        end else begin
            h = HALF_W'(window >> 1);
        end
        return h;
    endfunction

endpackage

// ===== rtl/cma_divider.sv =====
// ----------------------------------------------------------------------------
// cma_divider
// serial signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
`include "centered_moving_average_unit_macros.svh"

module cma_divider import cma_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [SUM_W-1:0] i_dividend,
    input  logic [CNT_W-1:0]        i_divisor,
    output logic                    o_busy,
    output logic signed [SUM_W-1:0] o_quotient
);

    logic              r_busy;
    logic [DCNT_W-1:0] r_cnt;
    logic [SUM_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_rem;
    logic [CNT_W-1:0]  r_div;
    logic              r_neg;
    logic [SUM_W-1:0]  w_mag;
    logic [CNT_W:0]    w_shift;
    logic [CNT_W:0]    w_diff;
    logic              w_ge;

    // magnitude of the dividend
    assign w_mag = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);

    // restoring step
    assign w_shift = {r_rem, r_quo[SUM_W-1]};
    assign w_diff  = w_shift - {1'b0, r_div};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    // iteration control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(SUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - DCNT_W'(1);
            if (r_cnt == DCNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // quotient and remainder
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= w_mag;
            r_rem <= '0;
            r_div <= i_divisor;
            r_neg <= i_dividend[SUM_W-1];
        end else if (r_busy) begin
            r_quo <= {r_quo[SUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[CNT_W-1:0] : w_shift[CNT_W-1:0];
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_neg ? signed'(-r_quo) : signed'(r_quo);

    // partial remainder always below the divisor
    `CMA_ASSERT_IMP(a_rem_below_div, r_busy, r_rem < r_div, "divider remainder out of range")

endmodule

// ===== rtl/cma_datapath.sv =====
// ----------------------------------------------------------------------------
// cma_datapath
// history memory, running sum, edge trimming, divider and output register
// ----------------------------------------------------------------------------
`include "centered_moving_average_unit_macros.svh"

module cma_datapath import cma_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  t_cmd                      i_cmd,
    output t_sts                      o_sts,
    input  logic [CFG_W-1:0]          i_window,
    input  logic signed [FIELD_W-1:0] i_sample_value,
    input  logic signed [FIELD_W-1:0] i_sample_temperature,
    input  logic [FIELD_W-1:0]        i_sample_time,
    input  logic                      i_end_of_curve,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [FIELD_W-1:0] o_smoothed_value,
    output logic signed [FIELD_W-1:0] o_point_temperature,
    output logic [FIELD_W-1:0]        o_point_time,
    output logic                      o_last_point
);

    logic [HALF_W-1:0]       r_half;
    logic [HALF_W-1:0]       r_age;
    logic [HALF_W-1:0]       w_cur_half;
    logic [CNT_W-1:0]        r_pr;
    logic [CNT_W-1:0]        r_fc;
    logic [CNT_W-1:0]        w_span;
    logic [CNT_W-1:0]        w_reach;
    logic [CNT_W-1:0]        w_target;
    logic signed [SUM_W-1:0] r_sum;
    logic signed [SUM_W-1:0] r_fsum;
    logic signed [SUM_W-1:0] w_new_val;
    logic signed [SUM_W-1:0] w_rd_val;
    logic signed [SUM_W-1:0] w_quo;
    logic                    r_sub;
    logic                    r_last;
    logic                    w_main;
    logic                    w_need_trim;
    logic                    w_final;
    logic                    w_div_busy;
    logic [ADDR_W-1:0]       r_ptr;
    logic [ADDR_W-1:0]       w_wr_addr;
    logic [ADDR_W-1:0]       w_rd_addr;
    logic                    w_rd_en;
    logic [MEM_W-1:0]        w_wr_data;
    logic [MEM_W-1:0]        r_rd_data;
    logic [MEM_W-1:0]        r_mem [MEM_DEPTH];
    logic                    r_out_valid;
    logic signed [FIELD_W-1:0] r_out_value;
    logic signed [FIELD_W-1:0] r_out_temp;
    logic [FIELD_W-1:0]      r_out_time;
    logic                    r_out_last;

    // half span is latched on the first point of a curve
    assign w_cur_half = (r_pr == '0) ? eff_half(i_window) : r_half;
    assign w_span     = CNT_W'({w_cur_half, 1'b1});

    // value fields widened for the sums
    assign w_new_val = SUM_W'(signed'(i_sample_value[VALUE_W-1:0]));
    assign w_rd_val  = SUM_W'(signed'(r_rd_data[MEM_W-1 -: VALUE_W]));

    // count summed for the result at the current age
    assign w_reach     = CNT_W'(r_age) + CNT_W'(r_half) + CNT_W'(1);
    assign w_target    = (w_reach < r_pr) ? w_reach : r_pr;
    assign w_main      = (r_pr > CNT_W'(r_half));
    assign w_need_trim = (r_fc > w_target);
    assign w_final     = !r_last || (r_age == '0);

    // status to the controller
    assign o_sts.has_result   = w_main || r_last;
    assign o_sts.need_trim    = w_need_trim;
    assign o_sts.div_busy     = w_div_busy;
    assign o_sts.out_free     = !r_out_valid || i_out_ready;
    assign o_sts.final_result = w_final;

    // history write, newest entry at r_ptr
    assign w_wr_addr = r_ptr + ADDR_W'(1);
    assign w_wr_data = {i_sample_value[VALUE_W-1:0], i_sample_temperature, i_sample_time};

    // read select: oldest value on accept, trimmed value, centre point fields
    always_comb begin
        w_rd_en   = 1'b0;
        w_rd_addr = r_ptr - ADDR_W'(r_age);
        if (i_cmd.accept) begin
            w_rd_en   = 1'b1;
            w_rd_addr = r_ptr - ADDR_W'({w_cur_half, 1'b0});
        end else if (i_cmd.tgt) begin
            w_rd_en   = w_need_trim;
            w_rd_addr = r_ptr - ADDR_W'(r_fc - CNT_W'(1));
        end else if (i_cmd.div_start) begin
            w_rd_en = 1'b1;
        end
    end

    // history memory
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (w_rd_en) begin
            r_rd_data <= r_mem[w_rd_addr];
        end
    end

    // curve state and result loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr       <= '0;
            r_pr        <= '0;
            r_half      <= '0;
            r_sum       <= '0;
            r_sub       <= 1'b0;
            r_last      <= 1'b0;
            r_age       <= '0;
            r_fc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.accept) begin
                r_ptr  <= w_wr_addr;
                r_half <= w_cur_half;
                r_sub  <= (r_pr >= w_span);
                r_pr   <= (r_pr < w_span) ? r_pr + CNT_W'(1) : r_pr;
                r_sum  <= r_sum + w_new_val;
                r_last <= i_end_of_curve;
            end
            if (i_cmd.sub && r_sub) begin
                r_sum <= r_sum - w_rd_val;
            end
            if (i_cmd.setup) begin
                r_age <= w_main ? r_half : HALF_W'(r_pr - CNT_W'(1));
                r_fc  <= r_pr;
            end
            if (i_cmd.trim) begin
                r_fc <= r_fc - CNT_W'(1);
            end
            if (i_cmd.emit) begin
                if (w_final) begin
                    if (r_last) begin
                        r_pr  <= '0;
                        r_sum <= '0;
                    end
                end else begin
                    r_age <= r_age - HALF_W'(1);
                end
            end
            // output register
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // partial sum for trimmed windows and result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.setup) begin
            r_fsum <= r_sum;
        end
        if (i_cmd.trim) begin
            r_fsum <= r_fsum - w_rd_val;
        end
        if (i_cmd.emit) begin
            r_out_value <= FIELD_W'(w_quo);
            r_out_temp  <= r_rd_data[2*FIELD_W-1 -: FIELD_W];
            r_out_time  <= r_rd_data[FIELD_W-1:0];
            r_out_last  <= r_last && (r_age == '0);
        end
    end

    // mean by serial division
    cma_divider u_divider (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_fsum),
        .i_divisor  (r_fc),
        .o_busy     (w_div_busy),
        .o_quotient (w_quo)
    );

    assign o_out_valid         = r_out_valid;
    assign o_smoothed_value    = r_out_value;
    assign o_point_temperature = r_out_temp;
    assign o_point_time        = r_out_time;
    assign o_last_point        = r_out_last;

    // point count never passes the latched span
    `CMA_ASSERT_IMP(a_pr_in_span, 1'b1, r_pr <= CNT_W'({r_half, 1'b1}), "point count beyond span")
    // never divide by zero
    `CMA_ASSERT_IMP(a_div_nonzero, i_cmd.div_start, r_fc != '0, "division by zero count")
    // curve state cleared after the final result of a curve
    `CMA_ASSERT_NXT(a_curve_clear, i_cmd.emit && w_final && r_last, (r_pr == '0) && (r_sum == '0), "curve state not cleared")

endmodule

// ===== rtl/cma_controller.sv =====
// ----------------------------------------------------------------------------
// cma_controller
// sequences one request: accept, sum update, then one division per result
// ----------------------------------------------------------------------------
module cma_controller import cma_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUB,
        S_SETUP,
        S_TGT,
        S_TRIM,
        S_DSTART,
        S_DIV,
        S_EMIT
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_SUB;
                end
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_SETUP;
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = i_sts.has_result ? S_TGT : S_IDLE;
            end
            S_TGT: begin
                o_cmd.tgt = 1'b1;
                n_state   = i_sts.need_trim ? S_TRIM : S_DSTART;
            end
            S_TRIM: begin
                o_cmd.trim = 1'b1;
                n_state    = S_DSTART;
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DIV;
            end
            S_DIV: begin
                if (!i_sts.div_busy) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = i_sts.final_result ? S_IDLE : S_TGT;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

endmodule

// ===== rtl/centered_moving_average_unit.sv =====
// ----------------------------------------------------------------------------
// centered_moving_average_unit
// centered moving average over a streamed curve with truncated edges
// ----------------------------------------------------------------------------
// One request is taken at a time. A mid-curve point is accepted, its oldest
// value is subtracted from the sum and its result loop is set up; the result
// then takes a trim step where the window loses a point at the trailing edge,
// a divider start, a wait on the serial divider, which produces one quotient
// bit per cycle of the 39-bit window sum, and an emit held by output stalls.
// The first half points of a curve give no result. The final point of a curve
// flushes up to half+1 results. A new request is taken while the last result
// still waits in the output register. The history lives in a 128 x 96 memory
// with no clearing pass; it is usable straight out of reset. The window
// register (byte address 0, reset 5) is latched on the first point of a curve,
// so write it between curves; zero acts as one and values above 64 act as 64.
`include "centered_moving_average_unit_macros.svh"

module centered_moving_average_unit import cma_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // configuration port
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [PADDR_W-1:0]        paddr,
    input  logic [PDATA_W-1:0]        pwdata,
    output logic [PDATA_W-1:0]        prdata,
    output logic                      pready,
    // input points
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic signed [FIELD_W-1:0] i_sample_value,
    input  logic signed [FIELD_W-1:0] i_sample_temperature,
    input  logic [FIELD_W-1:0]        i_sample_time,
    input  logic                      i_end_of_curve,
    // smoothed points
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic signed [FIELD_W-1:0] o_smoothed_value,
    output logic signed [FIELD_W-1:0] o_point_temperature,
    output logic [FIELD_W-1:0]        o_point_time,
    output logic                      o_last_point
);

    logic [CFG_W-1:0] r_window;
    logic             w_sel_window;
    t_cmd             w_cmd;
    t_sts             w_sts;

    // register decode, one word per register
    assign w_sel_window = (paddr[2] == REG_WINDOW);

    // window register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= CFG_W'(WINDOW_RESET);
        end else if (psel && penable && pwrite && w_sel_window) begin
            r_window <= pwdata[CFG_W-1:0];
        end
    end

    assign prdata = w_sel_window ? PDATA_W'(r_window) : '0;
    assign pready = 1'b1;

    // sequencer
    cma_controller u_controller (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    // datapath
    cma_datapath u_datapath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (w_cmd),
        .o_sts                (w_sts),
        .i_window             (r_window),
        .i_sample_value       (i_sample_value),
        .i_sample_temperature (i_sample_temperature),
        .i_sample_time        (i_sample_time),
        .i_end_of_curve       (i_end_of_curve),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_smoothed_value     (o_smoothed_value),
        .o_point_temperature  (o_point_temperature),
        .o_point_time         (o_point_time),
        .o_last_point         (o_last_point)
    );

endmodule

// ===== tb/sv/centered_moving_average_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// centered_moving_average_unit_test
// streams curves of points through the smoothing unit under several window
// settings and idle patterns, predicts every smoothed point in the bench and
// compares each output request field by field in arrival order
// ----------------------------------------------------------------------------
module centered_moving_average_unit_test import cma_pkg::*;;

    localparam int RESET_CYCLES  = 6;
    localparam int SETTLE_CYCLES = 120;
    localparam int CYCLE_LIMIT   = 4000000;
    localparam int RANDOM_ITEMS  = 410;
    localparam int MAX_CURVE_LEN = 90;
    localparam logic [PADDR_W-1:0] WINDOW_ADDR = PADDR_W'(4 * int'(REG_WINDOW));
    localparam logic [FIELD_W-1:0] VALUE_MAX   = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] VALUE_MIN   = 32'h8000_0000;
    localparam logic [FIELD_W-1:0] ALL_ONES    = 32'hFFFF_FFFF;

    typedef struct packed {
        logic signed [FIELD_W-1:0] mean;
        logic signed [FIELD_W-1:0] temp;
        logic [FIELD_W-1:0]        stamp;
        logic                      last_flag;
    } t_smooth_point;

    // block ports
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      psel = 1'b0;
    logic                      penable = 1'b0;
    logic                      pwrite = 1'b0;
    logic [PADDR_W-1:0]        paddr = '0;
    logic [PDATA_W-1:0]        pwdata = '0;
    logic [PDATA_W-1:0]        prdata;
    logic                      pready;
    logic                      i_in_valid = 1'b0;
    logic                      o_in_ready;
    logic [FIELD_W-1:0]        i_sample_value = '0;
    logic [FIELD_W-1:0]        i_sample_temperature = '0;
    logic [FIELD_W-1:0]        i_sample_time = '0;
    logic                      i_end_of_curve = 1'b0;
    logic                      o_out_valid;
    logic                      i_out_ready = 1'b0;
    logic signed [FIELD_W-1:0] o_smoothed_value;
    logic signed [FIELD_W-1:0] o_point_temperature;
    logic [FIELD_W-1:0]        o_point_time;
    logic                      o_last_point;

    // predictor state
    logic [CFG_W-1:0]   cfg_window = CFG_W'(WINDOW_RESET);
    longint             value_hist [SPAN_MAX];
    logic [FIELD_W-1:0] temp_line [MAX_HALF+1];
    logic [FIELD_W-1:0] stamp_line [MAX_HALF+1];
    longint             window_sum = 0;
    int unsigned        curve_count = 0;
    int unsigned        curve_half = 0;
    t_smooth_point      expected_points [$];

    int error_count = 0;
    int cycle_count = 0;
    int send_gap_pct = 0;
    int stall_pct = 0;

    centered_moving_average_unit u_top (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_ready           (o_in_ready),
        .i_sample_value       (i_sample_value),
        .i_sample_temperature (i_sample_temperature),
        .i_sample_time        (i_sample_time),
        .i_end_of_curve       (i_end_of_curve),
        .o_out_valid          (o_out_valid),
        .i_out_ready          (i_out_ready),
        .o_smoothed_value     (o_smoothed_value),
        .o_point_temperature  (o_point_temperature),
        .o_point_time         (o_point_time),
        .o_last_point         (o_last_point)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // queue one smoothed point: mean truncated toward zero, centre fields by age
    function automatic void push_mean(input longint sum, input int unsigned cnt,
                                      input int unsigned age, input logic last_flag);
        t_smooth_point p;
        longint        mean;
        int unsigned   a;
        mean = sum / longint'(cnt);
        a = (age <= MAX_HALF) ? age : MAX_HALF;
        p.mean      = FIELD_W'(mean);
        p.temp      = temp_line[a];
        p.stamp     = stamp_line[a];
        p.last_flag = last_flag;
        expected_points.push_back(p);
    endfunction

    // advance the smoothing state by one accepted point
    task automatic predict_point(input logic [FIELD_W-1:0] val,
                                 input logic [FIELD_W-1:0] temp,
                                 input logic [FIELD_W-1:0] stamp, input logic eoc);
        int unsigned w;
        int unsigned half;
        int unsigned span;
        int unsigned pending;
        int unsigned age;
        int unsigned cnt;
        longint      s;
        // half span latched on the first point of a curve
        if (curve_count == 0) begin
            w = cfg_window;
            if (w < 1) w = 1;
            if (w > MAX_WINDOW) w = MAX_WINDOW;
            curve_half = w / 2;
        end
        half = curve_half;
        span = 2 * half + 1;

        if (curve_count >= span) window_sum -= value_hist[span-1];
        for (int i = SPAN_MAX - 1; i > 0; i--) value_hist[i] = value_hist[i-1];
        value_hist[0] = longint'($signed(val));
        for (int i = MAX_HALF; i > 0; i--) begin
            temp_line[i]  = temp_line[i-1];
            stamp_line[i] = stamp_line[i-1];
        end
        temp_line[0]  = temp;
        stamp_line[0] = stamp;
        window_sum += longint'($signed(val));
        if (curve_count < span) curve_count++;

        pending = eoc ? ((curve_count < half) ? curve_count : half) : 0;
        if (curve_count >= half + 1) begin
            push_mean(window_sum, curve_count, half, eoc && (pending == 0));
        end
        // end of curve: flush the tail with a shrinking window
        for (int unsigned m = pending; m > 0; m--) begin
            age = m - 1;
            cnt = age + half + 1;
            if (cnt > curve_count) cnt = curve_count;
            s = 0;
            for (int unsigned d = 0; d < cnt; d++) s += value_hist[d];
            push_mean(s, cnt, age, age == 0);
        end
        if (eoc) begin
            curve_count = 0;
            window_sum  = 0;
        end
    endtask

    // result checker
    always @(posedge i_clk) begin : check_results
        t_smooth_point want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_points.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual value %0d",
                         $time, o_smoothed_value);
                error_count = error_count + 1;
            end else begin
                want = expected_points.pop_front();
                if (o_smoothed_value !== want.mean) begin
                    $display("%0t: smoothed_value expected %0d actual %0d",
                             $time, want.mean, o_smoothed_value);
                    error_count = error_count + 1;
                end
                if (o_point_temperature !== want.temp) begin
                    $display("%0t: point_temperature expected %0d actual %0d",
                             $time, want.temp, o_point_temperature);
                    error_count = error_count + 1;
                end
                if (o_point_time !== want.stamp) begin
                    $display("%0t: point_time expected %h actual %h",
                             $time, want.stamp, o_point_time);
                    error_count = error_count + 1;
                end
                if (o_last_point !== want.last_flag) begin
                    $display("%0t: last_point expected %b actual %b",
                             $time, want.last_flag, o_last_point);
                    error_count = error_count + 1;
                end
            end
        end
    end

    // send one input request, with random idle cycles ahead of it
    task automatic send_point(input logic [FIELD_W-1:0] val, input logic [FIELD_W-1:0] temp,
                              input logic [FIELD_W-1:0] stamp, input logic eoc);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid           <= 1'b1;
        i_sample_value       <= val;
        i_sample_temperature <= temp;
        i_sample_time        <= stamp;
        i_end_of_curve       <= eoc;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        predict_point(val, temp, stamp, eoc);
    endtask

    // hold the sender until every expected result is out, then let the block settle
    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // register write, upper data bits random
    task automatic write_window(input logic [CFG_W-1:0] win);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= WINDOW_ADDR;
        pwdata  <= (PDATA_W'($urandom) & ~PDATA_W'({CFG_W{1'b1}})) | PDATA_W'(win);
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        cfg_window = win;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    function automatic logic [FIELD_W-1:0] rand_value();
        case ($urandom_range(0, 9))
            0: return VALUE_MAX;
            1: return VALUE_MIN;
            2: return FIELD_W'($urandom_range(0, 200)) - FIELD_W'(100);
            default: return FIELD_W'($urandom);
        endcase
    endfunction

    // mostly small windows, some large, some at the edges of the register
    function automatic logic [CFG_W-1:0] pick_window();
        case ($urandom_range(0, 9))
            0: begin
                case ($urandom_range(0, 6))
                    0: return CFG_W'(0);
                    1: return CFG_W'(1);
                    2: return CFG_W'(2);
                    3: return CFG_W'(MAX_WINDOW - 1);
                    4: return CFG_W'(MAX_WINDOW);
                    5: return CFG_W'(MAX_WINDOW + 1);
                    default: return {CFG_W{1'b1}};
                endcase
            end
            1: return CFG_W'($urandom_range(21, 127));
            default: return CFG_W'($urandom_range(1, 12));
        endcase
    endfunction

    // reset window, extremes of every field
    task automatic test_default_window();
        logic [FIELD_W-1:0] vals [7] = '{VALUE_MAX, VALUE_MAX, VALUE_MIN, VALUE_MIN,
                                         '0, ALL_ONES, 32'd1};
        for (int k = 0; k < 7; k++) begin
            send_point(vals[k], (k % 2 == 0) ? VALUE_MAX : VALUE_MIN,
                       (k % 2 == 0) ? '0 : ALL_ONES, k == 6);
        end
        wait_idle();
    endtask

    // zero acts as one: every point is its own mean
    task automatic test_window_zero();
        write_window(CFG_W'(0));
        send_point(VALUE_MAX, 32'h1234_5678, 32'h0000_0001, 1'b0);
        send_point(VALUE_MIN, ALL_ONES, 32'h8000_0000, 1'b0);
        send_point(32'd5, '0, ALL_ONES, 1'b1);
        wait_idle();
    endtask

    // even window, curve shorter than the span
    task automatic test_even_window();
        write_window(CFG_W'(6));
        for (int k = 0; k < 5; k++) begin
            send_point((k % 2 == 0) ? VALUE_MIN : ALL_ONES, FIELD_W'($urandom),
                       FIELD_W'($urandom), k == 4);
        end
        wait_idle();
    endtask

    // single-point curves at the largest and smallest window
    task automatic test_single_point();
        write_window(CFG_W'(MAX_WINDOW));
        send_point(VALUE_MIN, VALUE_MAX, ALL_ONES, 1'b1);
        wait_idle();
        write_window(CFG_W'(1));
        send_point(VALUE_MAX, VALUE_MIN, '0, 1'b1);
        wait_idle();
    endtask

    // window above the maximum saturates
    task automatic test_window_above_max();
        write_window({CFG_W{1'b1}});
        for (int k = 0; k < 4; k++) begin
            send_point(VALUE_MAX - FIELD_W'(k), FIELD_W'(k), FIELD_W'(k), k == 3);
        end
        wait_idle();
    endtask

    // random curves, new window on about half of them, else back to back
    task automatic test_random_curves(input int quota, input int gap, input int stall);
        int          sent;
        int          len;
        int unsigned w;
        int unsigned span;
        sent = 0;
        send_gap_pct = gap;
        stall_pct    = stall;
        while (sent < quota) begin
            if (sent == 0 || $urandom_range(0, 1) == 0) begin
                wait_idle();
                write_window(pick_window());
            end
            w = (cfg_window < 1) ? 1 : ((cfg_window > MAX_WINDOW) ? MAX_WINDOW : cfg_window);
            span = 2 * (w / 2) + 1;
            case ($urandom_range(0, 9))
                0: len = 1;
                1: len = $urandom_range(span, 3 * span);
                default: len = $urandom_range(1, span + 12);
            endcase
            if (len > MAX_CURVE_LEN) len = MAX_CURVE_LEN;
            // last curve of the phase ends at the quota
            if (len > quota - sent) len = quota - sent;
            for (int k = 0; k < len; k++) begin
                send_point(rand_value(), FIELD_W'($urandom), FIELD_W'($urandom), k == len - 1);
                sent++;
            end
        end
        wait_idle();
    endtask

    // test sequence
    initial begin
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_gap_pct = 20;
        stall_pct    = 20;
        test_default_window();
        test_window_zero();
        test_even_window();
        test_single_point();
        test_window_above_max();
        test_random_curves(RANDOM_ITEMS / 4, 0, 0);
        test_random_curves(RANDOM_ITEMS / 4, 54, 0);
        test_random_curves(RANDOM_ITEMS / 4, 0, 54);
        test_random_curves(RANDOM_ITEMS / 4, 8, 8);
        wait_idle();
        if (error_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
